// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpla_pkg.sv =====
// shared types, constants and helper functions for the point light accumulator
// no dependencies
`timescale 1ns / 1ps

package tpla_pkg;

    localparam int MAX_LIGHTS = 64;
    localparam int IDX_W      = $clog2(MAX_LIGHTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ENTRY_W    = 52;
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int STEP_W     = $clog2(ROOT_W);

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    // register indexes
    localparam logic REG_AMB_LEVEL = 1'b0;
    localparam logic REG_AMB_COLOR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMB_MUL,
        ST_AMB_ACC,
        ST_READ,
        ST_LOAD,
        ST_SQX,
        ST_SQY,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_CMP,
        ST_CH_MUL,
        ST_CH_ACC,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  color;
        logic [7:0]  level;
        logic [3:0]  z;
        logic [15:0] y;
        logic [15:0] x;
    } light_t;

    // palette channel lookup, ch 0 red, 1 green, 2 blue
    function automatic logic [7:0] pal_channel(input logic [7:0] idx, input logic [1:0] ch);
        logic [23:0] rgb;
        if (idx >= 8'd16) begin
            rgb = 24'hFFDCB4;
        end else begin
            case (idx[3:0])
                4'd0:    rgb = 24'h000000;
                4'd1:    rgb = 24'hFFFFFF;
                4'd2:    rgb = 24'hFFB200;
                4'd3:    rgb = 24'hB4B4B4;
                4'd4:    rgb = 24'h00FF00;
                4'd5:    rgb = 24'hFF0000;
                4'd6:    rgb = 24'h0000FF;
                4'd7:    rgb = 24'hB4B400;
                4'd8:    rgb = 24'hFF3232;
                4'd9:    rgb = 24'h6464FF;
                4'd10:   rgb = 24'hFF6464;
                4'd11:   rgb = 24'h64FF64;
                4'd12:   rgb = 24'h6464FF;
                4'd13:   rgb = 24'hFFFF64;
                4'd14:   rgb = 24'hFF64FF;
                default: rgb = 24'h64FFFF;
            endcase
        end
        case (ch)
            2'd0:    pal_channel = rgb[23:16];
            2'd1:    pal_channel = rgb[15:8];
            default: pal_channel = rgb[7:0];
        endcase
    endfunction

    // floor(x / 255) by reciprocal multiply and one correction step
    function automatic logic [8:0] div255(input logic [15:0] x);
        logic [24:0] m;
        logic [8:0]  q;
        logic [16:0] qm;
        logic [16:0] r;
        m  = {9'b0, x} * 25'd257;
        q  = m[24:16];
        qm = {8'b0, q} * 17'd255;
        r  = {1'b0, x} - qm;
        if (r >= 17'd255) begin
            q = q + 9'd1;
        end
        return q;
    endfunction

endpackage

// ===== hw/rtl/tpla_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tpla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tpla_isqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
// depends on tpla_pkg
`timescale 1ns / 1ps

module tpla_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tpla_pkg::SQ_W-1:0] operand,
    output logic                      done,
    output logic [tpla_pkg::ROOT_W-1:0] root
);
    import tpla_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]   val_reg, val_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+3:0] rem_shift;
    logic [ROOT_W+3:0] trial;

    assign rem_shift = {rem_reg, val_reg[SQ_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign done      = busy_reg && (cnt_reg == STEP_W'(ROOT_W - 1));
    assign root      = root_reg;

    // one root bit per step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = operand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[SQ_W-3:0], 2'b00};
            cnt_next = cnt_reg + STEP_W'(1);
            if (rem_shift >= trial)
            begin
                rem_next  = (ROOT_W+2)'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (ROOT_W+2)'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

// ===== hw/rtl/tile_point_light_accumulator.sv =====
// top level of the tile point light accumulator: sequencer, light table, output register
// depends on tpla_pkg, tpla_ram, tpla_isqrt and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   s_* channel takes one item per transfer: tuser holds the kind (clear, add, query),
//   tdata the tile position, floor, intensity and palette index of a light or query.
//   m_* channel gives exactly one result per item: rgb for a query, zeros otherwise,
//   plus a flag set when an add was dropped on a full table.
//   The APB port sets ambient level (0x0) and ambient color index (0x4).
// Sequencing
//   clear and add: the result is valid in the cycle after the transfer.
//   query: ambient multiply and accumulate per channel, then a table read per light;
//   a light on another floor is skipped, one on the same floor is squared, rooted by
//   the 25-step square root unit and held to its reach, one in reach adds per channel;
//   the result is registered once the output is free. No new item is taken meanwhile.
// Reset
//   the light table becomes empty and both registers read zero; table contents
//   are not cleared, only the count.
// Stall
//   a result waits in the output register; the input side is held off while that register
//   holds a result that m_tready does not take, and while a query is in progress.
module tile_point_light_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pos_x[15:0], pos_y[31:16], floor_level[35:32], light_level[43:36],
    //        light_color[51:44], zero pad[55:52]
    input  logic [55:0] s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: red[7:0], green[15:8], blue[23:16], table_full[24], zero pad[31:25]
    output logic [31:0] m_tdata
);
    import tpla_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [1:0]        ch_reg, ch_next;
    logic [7:0]        amb_level_reg, amb_color_reg;
    logic [15:0]       qx_reg, qx_next, qy_reg, qy_next;
    logic [3:0]        qz_reg, qz_next;
    light_t            ent_reg, ent_next;
    logic [15:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]       prod_reg, prod_next;
    logic [32:0]       sq_reg, sq_next;
    logic [15:0]       diff_reg, diff_next;
    logic [7:0]        rgb_reg [3];
    logic [7:0]        rgb_next [3];
    logic              out_valid_reg, out_valid_next;
    logic [24:0]       out_reg, out_next;

    logic [15:0]       mul_a, mul_b;
    logic              s_xfer, out_free, cfg_wr;
    logic              ram_we;
    light_t            ram_wdata, ram_rdata;
    logic              root_start, root_done;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   root_operand;
    logic [ROOT_W:0]   two_d;
    logic [8:0]        quot;
    logic [9:0]        sum9;
    light_t            in_light;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_AMB_COLOR) ? {24'b0, amb_color_reg}
                                                  : {24'b0, amb_level_reg};
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg};

    assign in_light = '{color: s_tdata[51:44], level: s_tdata[43:36], z: s_tdata[35:32],
                        y: s_tdata[31:16], x: s_tdata[15:0]};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_level_reg <= '0;
            amb_color_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_AMB_LEVEL)
            begin
                amb_level_reg <= pwdata[7:0];
            end
            else
            begin
                amb_color_reg <= pwdata[7:0];
            end
        end
    end

    // light table
    tpla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LIGHTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_wdata = in_light;

    // distance unit
    assign root_operand = {1'b0, sq_reg + {1'b0, prod_reg}, 16'b0};

    tpla_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (root_operand),
        .done    (root_done),
        .root    (root)
    );

    assign two_d = {root, 1'b0};

    // shared divide by 255 on the product
    assign quot = (state_reg == ST_AMB_ACC) ? div255(prod_reg[15:0]) : div255(prod_reg[23:8]);
    assign sum9 = {2'b0, rgb_reg[ch_reg]} + {1'b0, quot};

    // shared multiplier operand select
    always_comb
    begin
        mul_a = {8'b0, pal_channel(ent_reg.color, ch_reg)};
        mul_b = diff_reg;
        case (state_reg)
            ST_AMB_MUL:
            begin
                mul_a = {8'b0, pal_channel(amb_color_reg, ch_reg)};
                mul_b = {8'b0, amb_level_reg};
            end
            ST_SQX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            ST_SQY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qz_next        = qz_reg;
        ent_next       = ent_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        diff_next      = diff_reg;
        rgb_next       = rgb_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        root_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    case (s_tuser)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_ADD:
                        begin
                            if (in_light.level != 8'd0)
                            begin
                                if (count_reg >= CNT_W'(MAX_LIGHTS))
                                begin
                                    out_next[24] = 1'b1;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        MODE_QUERY:
                        begin
                            out_valid_next = 1'b0;
                            qx_next        = in_light.x;
                            qy_next        = in_light.y;
                            qz_next        = in_light.z;
                            idx_next       = '0;
                            ch_next        = '0;
                            state_next     = ST_AMB_MUL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_AMB_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_AMB_ACC;
            end
            ST_AMB_ACC:
            begin
                rgb_next[ch_reg] = quot[7:0];
                if (ch_reg == 2'd2)
                begin
                    ch_next    = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_AMB_MUL;
                end
            end
            ST_READ:
            begin
                state_next = (idx_reg == count_reg) ? ST_DONE : ST_LOAD;
            end
            ST_LOAD:
            begin
                ent_next = ram_rdata;
                dx_next  = (qx_reg >= ram_rdata.x) ? qx_reg - ram_rdata.x
                                                   : ram_rdata.x - qx_reg;
                dy_next  = (qy_reg >= ram_rdata.y) ? qy_reg - ram_rdata.y
                                                   : ram_rdata.y - qy_reg;
                state_next = (ram_rdata.z == qz_reg) ? ST_SQX : ST_NEXT;
            end
            ST_SQX:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                sq_next    = {1'b0, prod_reg};
                prod_next  = mul_a * mul_b;
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                diff_next = {ent_reg.level, 8'b0} - two_d[15:0];
                ch_next   = '0;
                if (two_d > {10'b0, ent_reg.level, 8'b0})
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_CH_MUL;
                end
            end
            ST_CH_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_CH_ACC;
            end
            ST_CH_ACC:
            begin
                rgb_next[ch_reg] = (sum9 > 10'd255) ? 8'd255 : sum9[7:0];
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_CH_MUL;
                end
            end
            ST_NEXT:
            begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_READ;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = {1'b0, rgb_reg[2], rgb_reg[1], rgb_reg[0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        qz_reg   <= qz_next;
        ent_reg  <= ent_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        diff_reg <= diff_next;
        rgb_reg  <= rgb_next;
        out_reg  <= out_next;
    end

    // checks
    `ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_LIGHTS), "light count above table size")
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, s_xfer && s_tuser == MODE_CLEAR, count_reg == '0, "clear did not empty the table")
    `ASSERT_NOW(a_full_no_color, clk, rst_n, m_tvalid && m_tdata[24], m_tdata[23:0] == 24'd0, "dropped add carries color")
    `ASSERT_NOW(a_walk_in_range, clk, rst_n, state_reg == ST_LOAD, idx_reg < count_reg, "table read past last light")

endmodule

// ===== tb/sv/tile_point_light_accumulator_tb.sv =====
// self-checking testbench for the tile point light accumulator
// drives clear/add/query items and an unused kind over the stream port and the ambient registers over apb
// depends on tpla_pkg and tile_point_light_accumulator
`timescale 1ns / 1ps

module tile_point_light_accumulator_tb;
    import tpla_pkg::*;

    typedef struct {
        mode_t       kind;
        logic [15:0] px;
        logic [15:0] py;
        logic [3:0]  fl;
        logic [7:0]  lvl;
        logic [7:0]  col;
    } item_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       full;
    } shade_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [3:0]  z;
        logic [7:0]  lvl;
        logic [7:0]  col;
    } lamp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    item_t  pending_items[$];
    shade_t expected_shades[$];
    lamp_t  lamps[MAX_LIGHTS];
    int     lamp_count = 0;
    logic [7:0] amb_level;
    logic [7:0] amb_color;
    int     errors = 0;
    int     sent_count = 0;
    int     query_count = 0;
    int     lit_count = 0;
    int     full_count = 0;
    int     src_idle_pct;
    int     sink_stall_pct;
    int     hold_cycles = 0;
    logic   hold_done = 1'b0;
    logic   long_hold_req;
    logic   in_taken;

    tile_point_light_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // watchdog
    initial
    begin
        #50000000;
        $display("tile_point_light_accumulator regression: fail");
        $finish;
    end

    function automatic logic [7:0] color_of(input logic [7:0] idx, input int ch);
        logic [7:0] rgb[3];
        case (idx)
            8'd0:  rgb = '{8'd0,   8'd0,   8'd0};
            8'd1:  rgb = '{8'd255, 8'd255, 8'd255};
            8'd2:  rgb = '{8'd255, 8'd178, 8'd0};
            8'd3:  rgb = '{8'd180, 8'd180, 8'd180};
            8'd4:  rgb = '{8'd0,   8'd255, 8'd0};
            8'd5:  rgb = '{8'd255, 8'd0,   8'd0};
            8'd6:  rgb = '{8'd0,   8'd0,   8'd255};
            8'd7:  rgb = '{8'd180, 8'd180, 8'd0};
            8'd8:  rgb = '{8'd255, 8'd50,  8'd50};
            8'd9:  rgb = '{8'd100, 8'd100, 8'd255};
            8'd10: rgb = '{8'd255, 8'd100, 8'd100};
            8'd11: rgb = '{8'd100, 8'd255, 8'd100};
            8'd12: rgb = '{8'd100, 8'd100, 8'd255};
            8'd13: rgb = '{8'd255, 8'd255, 8'd100};
            8'd14: rgb = '{8'd255, 8'd100, 8'd255};
            8'd15: rgb = '{8'd100, 8'd255, 8'd255};
            default: rgb = '{8'd255, 8'd220, 8'd180};
        endcase
        return rgb[ch];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // shade one item and update the lamp table
    function automatic shade_t shade_item(input item_t it);
        shade_t res;
        int unsigned acc[3];
        longint unsigned dx, dy, d8, reach, add;
        res = '{8'd0, 8'd0, 8'd0, 1'b0};
        acc = '{0, 0, 0};
        if (it.kind == MODE_CLEAR)
        begin
            lamp_count = 0;
        end
        else if (it.kind == MODE_ADD)
        begin
            if (it.lvl != 0)
            begin
                if (lamp_count >= MAX_LIGHTS)
                begin
                    res.full = 1'b1;
                end
                else
                begin
                    lamps[lamp_count] = '{it.px, it.py, it.fl, it.lvl, it.col};
                    lamp_count++;
                end
            end
        end
        else if (it.kind == MODE_QUERY)
        begin
            for (int ch = 0; ch < 3; ch++)
                acc[ch] = color_of(amb_color, ch) * amb_level / 255;
            for (int i = 0; i < lamp_count; i++)
            begin
                if (lamps[i].z != it.fl)
                    continue;
                dx = (it.px >= lamps[i].x) ? it.px - lamps[i].x : lamps[i].x - it.px;
                dy = (it.py >= lamps[i].y) ? it.py - lamps[i].y : lamps[i].y - it.py;
                d8 = int_sqrt((dx * dx + dy * dy) << 16);
                reach = longint'(lamps[i].lvl) << 8;
                if (2 * d8 > reach)
                    continue;
                for (int ch = 0; ch < 3; ch++)
                begin
                    add = color_of(lamps[i].col, ch) * (reach - 2 * d8) / 65280;
                    acc[ch] = acc[ch] + add;
                    if (acc[ch] > 255)
                        acc[ch] = 255;
                end
            end
            res.r = acc[0][7:0];
            res.g = acc[1][7:0];
            res.b = acc[2][7:0];
        end
        return res;
    endfunction

    // stream driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (s_tvalid && !in_taken)
        begin
            // hold the current transfer
        end
        else if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_items[0].kind;
            s_tdata  <= {4'd0, pending_items[0].col, pending_items[0].lvl,
                         pending_items[0].fl, pending_items[0].py, pending_items[0].px};
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // predict at acceptance
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            item_t it;
            shade_t sh;
            it = pending_items.pop_front();
            sh = shade_item(it);
            if (it.kind == MODE_QUERY)
            begin
                query_count++;
                if (sh.r != 0 || sh.g != 0 || sh.b != 0)
                    lit_count++;
            end
            if (sh.full)
                full_count++;
            expected_shades.insert(expected_shades.size(), sh);
            sent_count++;
        end
    end

    // receiver stall, with one long hold once requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (long_hold_req && !hold_done)
        begin
            hold_cycles <= 400;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_shades.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                errors++;
            end
            else
            begin
                shade_t want;
                want = expected_shades.pop_front();
                if (m_tdata[7:0] != want.r || m_tdata[15:8] != want.g ||
                    m_tdata[23:16] != want.b || m_tdata[24] != want.full ||
                    m_tdata[31:25] != 7'd0)
                begin
                    $display("%0t: mismatch expected rgb=%0d,%0d,%0d full=%0b %s",
                             $realtime, want.r, want.g, want.b, want.full, "actual");
                    $display("    rgb=%0d,%0d,%0d full=%0b",
                             m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[24]);
                    errors++;
                end
            end
        end
    end

    task automatic push_item(input mode_t k, input int x, input int y, input int f,
                             input int l, input int c);
        item_t it;
        it = '{k, x[15:0], y[15:0], f[3:0], l[7:0], c[7:0]};
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_shades.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic apb_write(input logic ridx, input logic [7:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (ridx == REG_AMB_LEVEL)
            amb_level = val;
        else
            amb_color = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random burst: mostly adds and queries around a spot, with some clears, random adds and unused kinds
    task automatic random_burst(input int n);
        int cx, cy, f, roll;
        cx = $urandom_range(65535);
        cy = $urandom_range(65535);
        f  = $urandom_range(15);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                push_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (roll < 4)
                push_item(mode_t'(2'd3), $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (roll < 40)
                push_item(MODE_ADD, (cx + $urandom_range(120)) & 16'hFFFF,
                          (cy + $urandom_range(120)) & 16'hFFFF,
                          ($urandom_range(3) == 0) ? $urandom_range(15) : f,
                          $urandom_range(255), $urandom_range(255));
            else if (roll < 45)
                push_item(MODE_ADD, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                push_item(MODE_QUERY, (cx + $urandom_range(120)) & 16'hFFFF,
                          (cy + $urandom_range(120)) & 16'hFFFF,
                          ($urandom_range(7) == 0) ? $urandom_range(15) : f, $urandom, $urandom);
        end
    endtask

    initial
    begin
        amb_level = 0; amb_color = 0;
        src_idle_pct = 0; sink_stall_pct = 0; long_hold_req = 1'b0;
        rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every kind, special cases
        push_item(MODE_QUERY, 0, 0, 0, 0, 0);
        push_item(MODE_ADD, 100, 100, 3, 0, 5);
        push_item(MODE_ADD, 100, 100, 3, 255, 1);
        push_item(MODE_ADD, 110, 95, 3, 20, 200);
        push_item(MODE_ADD, 65535, 65535, 15, 1, 255);
        push_item(MODE_ADD, 0, 0, 15, 255, 2);
        push_item(MODE_QUERY, 100, 100, 3, 0, 0);
        push_item(MODE_QUERY, 108, 100, 3, 0, 0);
        push_item(MODE_QUERY, 65535, 65535, 15, 255, 255);
        push_item(MODE_QUERY, 0, 1, 15, 0, 0);
        push_item(MODE_QUERY, 65535, 0, 15, 0, 0);
        push_item(mode_t'(2'd3), 65535, 65535, 15, 255, 255);
        push_item(MODE_CLEAR, 65535, 65535, 15, 255, 255);
        push_item(MODE_QUERY, 100, 100, 3, 0, 0);
        drain();
        apb_write(REG_AMB_LEVEL, 8'd255);
        apb_write(REG_AMB_COLOR, 8'd255);
        push_item(MODE_QUERY, 1, 2, 0, 0, 0);
        // fill the table past full, with one query reaching many lamps
        for (int i = 0; i < 66; i++)
            push_item(MODE_ADD, 500 + i % 4, 500, 7, 255, i);
        push_item(MODE_QUERY, 501, 500, 7, 0, 0);
        drain();

        // random phases through idle modes and register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            apb_write(REG_AMB_LEVEL, (ph == 2) ? 8'd0 : 8'($urandom_range(255)));
            apb_write(REG_AMB_COLOR, (ph == 5) ? 8'd0 : 8'($urandom_range(255)));
            push_item(MODE_CLEAR, 0, 0, 0, 0, 0);
            for (int b = 0; b < 5; b++)
                random_burst(30);
            if (ph == 3)
                long_hold_req = 1'b1;
            drain();
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;

        $display("items sent %0d, queries %0d (%0d lit), dropped adds on full table %0d",
                 sent_count, query_count, lit_count, full_count);
        if (errors == 0)
            $display("tile_point_light_accumulator regression: pass");
        else
            $display("tile_point_light_accumulator regression: fail");
        $finish;
    end

endmodule
